// ===== hw/rtl/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, register indexes, datapath commands and status for the
// midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

    // field widths
    localparam int RADIUS_BITS   = 10;
    localparam int COORD_BITS    = 11;
    localparam int OUT_BITS      = 13;
    localparam int DEC_BITS      = 48;
    localparam int STEP_BITS     = RADIUS_BITS + 1;
    localparam int SQ_BITS       = 2 * RADIUS_BITS;

    // shared multiplier operand and product widths
    localparam int MUL_A_BITS    = SQ_BITS + STEP_BITS;
    localparam int MUL_B_BITS    = SQ_BITS;
    localparam int MUL_P_BITS    = MUL_A_BITS + MUL_B_BITS;
    localparam int MUL_W_BITS    = (MUL_P_BITS > DEC_BITS) ? MUL_P_BITS : DEC_BITS;

    // configuration port
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = (RADIUS_BITS > COORD_BITS) ? RADIUS_BITS : COORD_BITS;

    // stream widths
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = ((8 * OUT_BITS + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_RADIUS_X = 2'd0,
        REG_RADIUS_Y = 2'd1,
        REG_CENTER_X = 2'd2,
        REG_CENTER_Y = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [RADIUS_BITS-1:0] radius_x;
        logic [RADIUS_BITS-1:0] radius_y;
        logic [COORD_BITS-1:0]  center_x;
        logic [COORD_BITS-1:0]  center_y;
    } cfg_regs_t;

    // datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_RS_SQX,
        OP_RS_SQY,
        OP_RS_MUL,
        OP_RS_FIN,
        OP_AD_P1,
        OP_AD_P2,
        OP_AD_CMP,
        OP_R1_STEP,
        OP_R2_M1,
        OP_R2_M2,
        OP_R2_M3,
        OP_R2_M4,
        OP_R2_STEP,
        OP_STOP,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit_valid;
    } dp_cmd_t;

    typedef struct packed {
        logic finished;
        logic region_two;
        logic step_le;
        logic y_zero;
    } dp_status_t;

    // result payload, last field in the lowest bits
    typedef struct packed {
        logic [OUT_BITS-1:0] py_d;
        logic [OUT_BITS-1:0] px_d;
        logic [OUT_BITS-1:0] py_c;
        logic [OUT_BITS-1:0] px_c;
        logic [OUT_BITS-1:0] py_b;
        logic [OUT_BITS-1:0] px_b;
        logic [OUT_BITS-1:0] py_a;
        logic [OUT_BITS-1:0] px_a;
    } out_result_t;

endpackage

// ===== hw/rtl/mer_cfg.sv =====
// ----------------------------------------------------------------------------
// mer_cfg
// Configuration register file: radii and centre, written by index.
// ----------------------------------------------------------------------------
module mer_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [mer_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [mer_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output mer_pkg::cfg_regs_t                 cfg
);

    mer_pkg::cfg_regs_t cfg_reg;

    // register writes, truncated to each register's width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                mer_pkg::REG_RADIUS_X: begin
                    cfg_reg.radius_x <= cfg_wdata[mer_pkg::RADIUS_BITS-1:0];
                end
                mer_pkg::REG_RADIUS_Y: begin
                    cfg_reg.radius_y <= cfg_wdata[mer_pkg::RADIUS_BITS-1:0];
                end
                mer_pkg::REG_CENTER_X: begin
                    cfg_reg.center_x <= cfg_wdata[mer_pkg::COORD_BITS-1:0];
                end
                mer_pkg::REG_CENTER_Y: begin
                    cfg_reg.center_y <= cfg_wdata[mer_pkg::COORD_BITS-1:0];
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/mer_datapath.sv =====
// ----------------------------------------------------------------------------
// mer_datapath
// Walk position, squared radii, decision variable and one shared multiplier;
// holds the result register loaded on an emit command.
// ----------------------------------------------------------------------------
module mer_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mer_pkg::dp_cmd_t      cmd,
    input  mer_pkg::cfg_regs_t    cfg,
    output mer_pkg::dp_status_t   status,
    output mer_pkg::out_result_t  result,
    output logic                  points_valid,
    output logic                  done_res
);

    localparam int DB = mer_pkg::DEC_BITS;
    localparam int SB = mer_pkg::STEP_BITS;
    localparam int OB = mer_pkg::OUT_BITS;

    // walk state
    logic [SB-1:0] x_reg, y_reg;
    logic          finished_reg, region2_reg;

    // arithmetic state
    logic [mer_pkg::SQ_BITS-1:0]    rx2_reg, ry2_reg;
    logic [mer_pkg::MUL_A_BITS-1:0] p1_reg, p2_reg;
    logic [DB-1:0]                  d_reg, acc_reg, prod_reg;

    // result register
    mer_pkg::out_result_t result_reg;
    logic                 valid_reg, done_reg;

    // multiplier
    logic [mer_pkg::MUL_A_BITS-1:0] mul_a;
    logic [mer_pkg::MUL_B_BITS-1:0] mul_b;
    logic [mer_pkg::MUL_W_BITS-1:0] mul_full;

    // step arithmetic
    logic [SB-1:0] x_inc, y_dec, r1_y;
    logic [DB-1:0] rx2_w, ry2_w, p1_w, p2_w, prod4;
    logic [DB-1:0] r1_inc, r2_inc;
    logic          d_neg;

    // coordinates
    logic [OB-1:0] cx, cy, xo, yo;

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            mer_pkg::OP_RS_SQX: begin
                mul_a = mer_pkg::MUL_A_BITS'(cfg.radius_x);
                mul_b = mer_pkg::MUL_B_BITS'(cfg.radius_x);
            end
            mer_pkg::OP_RS_SQY: begin
                mul_a = mer_pkg::MUL_A_BITS'(cfg.radius_y);
                mul_b = mer_pkg::MUL_B_BITS'(cfg.radius_y);
            end
            mer_pkg::OP_RS_MUL: begin
                mul_a = mer_pkg::MUL_A_BITS'(rx2_reg);
                mul_b = mer_pkg::MUL_B_BITS'(cfg.radius_y);
            end
            mer_pkg::OP_AD_P1: begin
                mul_a = mer_pkg::MUL_A_BITS'(ry2_reg);
                mul_b = mer_pkg::MUL_B_BITS'(x_reg);
            end
            mer_pkg::OP_AD_P2: begin
                mul_a = mer_pkg::MUL_A_BITS'(rx2_reg);
                mul_b = mer_pkg::MUL_B_BITS'(y_reg);
            end
            mer_pkg::OP_R2_M1: begin
                mul_a = p1_reg;
                mul_b = mer_pkg::MUL_B_BITS'(x_reg);
            end
            mer_pkg::OP_R2_M2: begin
                mul_a = p2_reg;
                mul_b = mer_pkg::MUL_B_BITS'(y_reg);
            end
            mer_pkg::OP_R2_M3: begin
                mul_a = mer_pkg::MUL_A_BITS'(rx2_reg);
                mul_b = mer_pkg::MUL_B_BITS'(ry2_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mer_pkg::MUL_W_BITS'(mul_a) * mer_pkg::MUL_W_BITS'(mul_b);

    // decision increments for one step in each region
    assign rx2_w  = DB'(rx2_reg);
    assign ry2_w  = DB'(ry2_reg);
    assign p1_w   = DB'(p1_reg);
    assign p2_w   = DB'(p2_reg);
    assign prod4  = prod_reg << 2;
    assign d_neg  = d_reg[DB-1];
    assign x_inc  = x_reg + SB'(1);
    assign y_dec  = y_reg - SB'(1);
    assign r1_y   = d_neg ? y_reg : y_dec;

    // region one: 8*ry2*(x+1) + 4*ry2, plus 8*rx2 - 8*rx2*y when y steps
    assign r1_inc = (p1_w << 3) + (ry2_w << 3) + (ry2_w << 2)
                  + (d_neg ? '0 : ((rx2_w << 3) - (p2_w << 3)));
    // region two: 12*rx2 - 8*rx2*y, plus 8*ry2*(x+1) when x steps
    assign r2_inc = (rx2_w << 3) + (rx2_w << 2) - (p2_w << 3)
                  + (d_neg ? ((p1_w << 3) + (ry2_w << 3)) : '0);

    // walk position and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg        <= '0;
            y_reg        <= '0;
            finished_reg <= 1'b1;
            region2_reg  <= 1'b0;
        end else begin
            case (cmd.op)
                mer_pkg::OP_RS_FIN: begin
                    x_reg        <= '0;
                    y_reg        <= SB'(cfg.radius_y);
                    region2_reg  <= 1'b0;
                    finished_reg <= (cfg.radius_x == '0) || (cfg.radius_y == '0);
                end
                mer_pkg::OP_R1_STEP: begin
                    x_reg        <= x_inc;
                    y_reg        <= r1_y;
                    finished_reg <= (r1_y == '0);
                end
                mer_pkg::OP_R2_M1: begin
                    region2_reg  <= 1'b1;
                end
                mer_pkg::OP_R2_STEP: begin
                    x_reg        <= d_neg ? x_inc : x_reg;
                    y_reg        <= y_dec;
                    finished_reg <= (y_dec == '0);
                end
                mer_pkg::OP_STOP: begin
                    finished_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // arithmetic registers, product registered every cycle
    always_ff @(posedge aclk) begin
        prod_reg <= mul_full[DB-1:0];
        case (cmd.op)
            mer_pkg::OP_RS_SQY: rx2_reg <= prod_reg[mer_pkg::SQ_BITS-1:0];
            mer_pkg::OP_RS_MUL: ry2_reg <= prod_reg[mer_pkg::SQ_BITS-1:0];
            mer_pkg::OP_RS_FIN: d_reg <= (ry2_w << 2) - prod4 + rx2_w;
            mer_pkg::OP_AD_P2:  p1_reg <= prod_reg[mer_pkg::MUL_A_BITS-1:0];
            mer_pkg::OP_AD_CMP: p2_reg <= prod_reg[mer_pkg::MUL_A_BITS-1:0];
            mer_pkg::OP_R1_STEP: d_reg <= d_reg + r1_inc;
            // ry2*(2x+1)^2 = 4x*P1 + 4*P1 + ry2
            mer_pkg::OP_R2_M2:  acc_reg <= prod4 + (p1_w << 2) + ry2_w;
            // 4*rx2*(y-1)^2 = 4y*P2 - 8*P2 + 4*rx2
            mer_pkg::OP_R2_M3:  acc_reg <= acc_reg + prod4 - (p2_w << 3) + (rx2_w << 2);
            mer_pkg::OP_R2_M4:  d_reg <= acc_reg - prod4;
            mer_pkg::OP_R2_STEP: d_reg <= d_reg + r2_inc;
            default: begin
            end
        endcase
    end

    // four mirrored points around the live centre
    assign cx = OB'(cfg.center_x);
    assign cy = OB'(cfg.center_y);
    assign xo = OB'(x_reg);
    assign yo = OB'(y_reg);

    always_ff @(posedge aclk) begin
        if (cmd.op == mer_pkg::OP_EMIT) begin
            valid_reg <= cmd.emit_valid;
            done_reg  <= finished_reg;
            if (cmd.emit_valid) begin
                result_reg.px_a <= cx + xo;
                result_reg.py_a <= cy + yo;
                result_reg.px_b <= cx - xo;
                result_reg.py_b <= cy - yo;
                result_reg.px_c <= cx - xo;
                result_reg.py_c <= cy + yo;
                result_reg.px_d <= cx + xo;
                result_reg.py_d <= cy - yo;
            end else begin
                result_reg <= '0;
            end
        end
    end

    // status; step_le is sampled while the second product sits in prod_reg
    assign status.finished   = finished_reg;
    assign status.region_two = region2_reg;
    assign status.step_le    = (p1_reg <= prod_reg[mer_pkg::MUL_A_BITS-1:0]);
    assign status.y_zero     = (y_reg == '0);

    assign result       = result_reg;
    assign points_valid = valid_reg;
    assign done_res     = done_reg;

    // a walk that has reached the axis is always marked finished
    a_yzero_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        (y_reg == '0) |-> finished_reg)
        else $error("walk at y zero without finished flag");

    // region two persists until a restart
    a_region_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (region2_reg && cmd.op != mer_pkg::OP_RS_FIN) |=> region2_reg)
        else $error("region two flag dropped without restart");

    // a stop command always leaves the walk finished
    a_stop_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == mer_pkg::OP_STOP) |=> finished_reg)
        else $error("stop command left walk unfinished");

endmodule

// ===== hw/rtl/mer_ctrl.sv =====
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer: accepts items, steps the datapath through restart, region one,
// region change, region two and stop sequences, and owns the output valid.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_restart,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  mer_pkg::dp_status_t  status,
    output mer_pkg::dp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RS_SQX,
        S_RS_SQY,
        S_RS_MUL,
        S_RS_FIN,
        S_AD_P1,
        S_AD_P2,
        S_AD_CMP,
        S_R1_STEP,
        S_R2_M1,
        S_R2_M2,
        S_R2_M3,
        S_R2_M4,
        S_R2_STEP,
        S_STOP,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   s_ready_reg, m_valid_reg, emit_valid_reg;
    logic   accept, emit_ok;

    assign accept  = s_tvalid && s_ready_reg;
    assign emit_ok = !m_valid_reg || m_tready;

    // state and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            s_ready_reg    <= 1'b1;
            m_valid_reg    <= 1'b0;
            emit_valid_reg <= 1'b0;
        end else begin
            // the emit step reloads the valid itself
            if (m_valid_reg && m_tready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        s_ready_reg <= 1'b0;
                        if (s_restart) begin
                            state_reg      <= S_RS_SQX;
                            emit_valid_reg <= 1'b1;
                        end else if (status.finished || status.y_zero) begin
                            state_reg      <= S_STOP;
                            emit_valid_reg <= 1'b0;
                        end else begin
                            state_reg      <= S_AD_P1;
                            emit_valid_reg <= 1'b1;
                        end
                    end
                end
                S_RS_SQX:  state_reg <= S_RS_SQY;
                S_RS_SQY:  state_reg <= S_RS_MUL;
                S_RS_MUL:  state_reg <= S_RS_FIN;
                S_RS_FIN:  state_reg <= S_EMIT;
                S_AD_P1:   state_reg <= S_AD_P2;
                S_AD_P2:   state_reg <= S_AD_CMP;
                S_AD_CMP: begin
                    if (status.region_two) begin
                        state_reg <= S_R2_STEP;
                    end else if (status.step_le) begin
                        state_reg <= S_R1_STEP;
                    end else begin
                        state_reg <= S_R2_M1;
                    end
                end
                S_R1_STEP: state_reg <= S_EMIT;
                S_R2_M1:   state_reg <= S_R2_M2;
                S_R2_M2:   state_reg <= S_R2_M3;
                S_R2_M3:   state_reg <= S_R2_M4;
                S_R2_M4:   state_reg <= S_R2_STEP;
                S_R2_STEP: state_reg <= S_EMIT;
                S_STOP:    state_reg <= S_EMIT;
                S_EMIT: begin
                    if (emit_ok) begin
                        m_valid_reg <= 1'b1;
                        s_ready_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // command decode
    always_comb begin
        cmd.emit_valid = emit_valid_reg;
        unique case (state_reg)
            S_IDLE:    cmd.op = mer_pkg::OP_NONE;
            S_RS_SQX:  cmd.op = mer_pkg::OP_RS_SQX;
            S_RS_SQY:  cmd.op = mer_pkg::OP_RS_SQY;
            S_RS_MUL:  cmd.op = mer_pkg::OP_RS_MUL;
            S_RS_FIN:  cmd.op = mer_pkg::OP_RS_FIN;
            S_AD_P1:   cmd.op = mer_pkg::OP_AD_P1;
            S_AD_P2:   cmd.op = mer_pkg::OP_AD_P2;
            S_AD_CMP:  cmd.op = mer_pkg::OP_AD_CMP;
            S_R1_STEP: cmd.op = mer_pkg::OP_R1_STEP;
            S_R2_M1:   cmd.op = mer_pkg::OP_R2_M1;
            S_R2_M2:   cmd.op = mer_pkg::OP_R2_M2;
            S_R2_M3:   cmd.op = mer_pkg::OP_R2_M3;
            S_R2_M4:   cmd.op = mer_pkg::OP_R2_M4;
            S_R2_STEP: cmd.op = mer_pkg::OP_R2_STEP;
            S_STOP:    cmd.op = mer_pkg::OP_STOP;
            S_EMIT:    cmd.op = emit_ok ? mer_pkg::OP_EMIT : mer_pkg::OP_NONE;
        endcase
    end

    assign s_tready = s_ready_reg;
    assign m_tvalid = m_valid_reg;

    // input is only taken while the sequencer is idle
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready_reg |-> state_reg == S_IDLE)
        else $error("ready raised outside idle");

    // a restart transfer always enters the restart sequence
    a_restart_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && accept && s_restart) |=> state_reg == S_RS_SQX)
        else $error("restart transfer did not start restart sequence");

    // a new result only comes from the emit step
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_EMIT)
        else $error("output valid raised outside emit");

    // a pending result blocks the emit step
    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && m_valid_reg && !m_tready) |-> cmd.op != mer_pkg::OP_EMIT)
        else $error("pending result overwritten");

endmodule

// ===== hw/rtl/midpoint_ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse walk: each transfer restarts or advances the walk by one
// decision step and returns the four mirrored pixels around the centre.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata[0] restart
//   m_       out  m_tvalid/m_tready  m_tdata 8 coords, m_tuser valid, m_tlast done
//   cfg_     in   cfg_we             cfg_addr index, cfg_wdata value
//
// A restart squares the radii and sets the decision; an advance forms the
// region products, then takes a region one or two step, recomputing the
// decision first on entering region two; an advance on a finished walk only
// stops. Each item ends at the emit step before the next is taken. One shared
// 31x20 multiplier forms every product. Reset is synchronous and clears the
// sequencer, the configuration registers and the walk position; after reset
// the walk reports finished. A result waiting on m_tready holds the sequencer
// at the emit step; the next item is taken while the previous result still waits.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // restart
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mer_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    // px_a, py_a, px_b, py_b, px_c, py_c, px_d, py_d
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mer_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    // points_valid
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [mer_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [mer_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    mer_pkg::cfg_regs_t    cfg;
    mer_pkg::dp_cmd_t      cmd;
    mer_pkg::dp_status_t   status;
    mer_pkg::out_result_t  result;

    // configuration registers
    mer_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sequencer
    mer_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_restart (s_tdata[0]),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // walk datapath and result register
    mer_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg          (cfg),
        .status       (status),
        .result       (result),
        .points_valid (m_tuser),
        .done_res     (m_tlast)
    );

    assign m_tdata = mer_pkg::OUT_TDATA_BITS'(result);

endmodule

// ===== test/ellipse_point_checker.sv =====
// ----------------------------------------------------------------------------
// ellipse_point_checker
// Watches the configuration port and both stream channels of the midpoint
// ellipse rasterizer, predicts the pixel group for every accepted item and
// compares each returned group field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ellipse_point_checker
    import mer_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    // restart
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    // px_a, py_a, px_b, py_b, px_c, py_c, px_d, py_d
    input  logic [OUT_TDATA_BITS-1:0] m_tdata,
    // points_valid
    input  logic                      m_tuser,
    input  logic                      m_tlast,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    output int unsigned               outstanding,
    output int unsigned               mismatches
);

    typedef struct packed {
        out_result_t pts;
        logic        plot;
        logic        done;
    } pixel_group_t;

    // register copies
    logic [RADIUS_BITS-1:0] rad_x, rad_y;
    logic [COORD_BITS-1:0]  ctr_x, ctr_y;

    // walk state
    logic [STEP_BITS-1:0]   walk_x, walk_y;
    logic [DEC_BITS-1:0]    dec_x4;
    logic                   in_region2;
    logic                   walk_done;
    logic [SQ_BITS-1:0]     sq_rx, sq_ry;

    pixel_group_t           predicted_groups[$];
    pixel_group_t           got, want;

    // four mirrored pixels around the centre, coordinates wrap at 13 bits
    function automatic pixel_group_t mirror_points(input logic plot, input logic done);
        pixel_group_t        g;
        logic [OUT_BITS-1:0] cx, cy, ox, oy;
        g  = '0;
        cx = {2'b00, ctr_x};
        cy = {2'b00, ctr_y};
        ox = {2'b00, walk_x};
        oy = {2'b00, walk_y};
        if (plot) begin
            g.pts.px_a = cx + ox;
            g.pts.py_a = cy + oy;
            g.pts.px_b = cx - ox;
            g.pts.py_b = cy - oy;
            g.pts.px_c = cx - ox;
            g.pts.py_c = cy + oy;
            g.pts.px_d = cx + ox;
            g.pts.py_d = cy - oy;
        end
        g.plot = plot;
        g.done = done;
        return g;
    endfunction

    // store the new position and decision, then emit
    function automatic pixel_group_t commit_step(input logic [63:0] sx, input logic [63:0] sy,
                                                 input logic [63:0] sum);
        walk_x    = sx[STEP_BITS-1:0];
        walk_y    = sy[STEP_BITS-1:0];
        dec_x4    = sum[DEC_BITS-1:0];
        walk_done = (walk_y == '0);
        return mirror_points(1'b1, walk_done);
    endfunction

    // one restart or one decision step of the walk
    function automatic pixel_group_t next_pixel_group(input logic restart);
        logic [63:0] rx2, ry2, sx, sy, dec, inc, full;
        if (restart) begin
            rx2        = 64'(rad_x);
            rx2        = rx2 * rx2;
            ry2        = 64'(rad_y);
            ry2        = ry2 * ry2;
            sy         = 64'(rad_y);
            sq_rx      = rx2[SQ_BITS-1:0];
            sq_ry      = ry2[SQ_BITS-1:0];
            walk_x     = '0;
            walk_y     = {1'b0, rad_y};
            in_region2 = 1'b0;
            full       = 4 * ry2 - 4 * rx2 * sy + rx2;
            dec_x4     = full[DEC_BITS-1:0];
            walk_done  = (rad_x == '0) || (rad_y == '0);
            return mirror_points(1'b1, walk_done);
        end
        // advance on a finished walk reports done with no points
        if (walk_done || walk_y == '0) begin
            walk_done = 1'b1;
            return mirror_points(1'b0, 1'b1);
        end
        rx2 = 64'(sq_rx);
        ry2 = 64'(sq_ry);
        sx  = 64'(walk_x);
        sy  = 64'(walk_y);
        dec = 64'(dec_x4);
        if (!in_region2) begin
            // region one: x always steps, y on a non-negative decision
            if (ry2 * sx <= rx2 * sy) begin
                inc = 8 * ry2 * (sx + 1) + 4 * ry2;
                if (!dec[DEC_BITS-1]) begin
                    inc = inc + 8 * rx2 - 8 * rx2 * sy;
                    sy  = sy - 1;
                end
                sx = sx + 1;
                return commit_step(sx, sy, dec + inc);
            end
            // region change: fresh region two decision, then a region two step
            in_region2 = 1'b1;
            full = ry2 * (2 * sx + 1) * (2 * sx + 1) + 4 * rx2 * (sy - 1) * (sy - 1)
                   - 4 * rx2 * ry2;
            dec  = full[DEC_BITS-1:0];
        end
        // region two: y always steps, x on a negative decision
        inc = 12 * rx2 - 8 * rx2 * sy;
        if (dec[DEC_BITS-1]) begin
            inc = inc + 8 * ry2 * (sx + 1);
            sx  = sx + 1;
        end
        sy = sy - 1;
        return commit_step(sx, sy, dec + inc);
    endfunction

    function automatic void check_field(input string name, input logic [OUT_BITS-1:0] exp_v,
                                        input logic [OUT_BITS-1:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, $signed(exp_v),
                     $signed(act_v));
        end
    endfunction

    // register writes, result transfers, then input transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            rad_x       = '0;
            rad_y       = '0;
            ctr_x       = '0;
            ctr_y       = '0;
            walk_x      = '0;
            walk_y      = '0;
            dec_x4      = '0;
            in_region2  = 1'b0;
            walk_done   = 1'b1;
            sq_rx       = '0;
            sq_ry       = '0;
            predicted_groups.delete();
            outstanding = 0;
            mismatches  = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_RADIUS_X: rad_x = cfg_wdata[RADIUS_BITS-1:0];
                    REG_RADIUS_Y: rad_y = cfg_wdata[RADIUS_BITS-1:0];
                    REG_CENTER_X: ctr_x = cfg_wdata[COORD_BITS-1:0];
                    REG_CENTER_Y: ctr_y = cfg_wdata[COORD_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.pts  = m_tdata;
                got.plot = m_tuser;
                got.done = m_tlast;
                if (predicted_groups.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected, got %h", $time, got);
                end else begin
                    want = predicted_groups.pop_front();
                    check_field("px_a", want.pts.px_a, got.pts.px_a);
                    check_field("py_a", want.pts.py_a, got.pts.py_a);
                    check_field("px_b", want.pts.px_b, got.pts.px_b);
                    check_field("py_b", want.pts.py_b, got.pts.py_b);
                    check_field("px_c", want.pts.px_c, got.pts.px_c);
                    check_field("py_c", want.pts.py_c, got.pts.py_c);
                    check_field("px_d", want.pts.px_d, got.pts.px_d);
                    check_field("py_d", want.pts.py_d, got.pts.py_d);
                    check_field("points_valid", {12'b0, want.plot}, {12'b0, got.plot});
                    check_field("done_res", {12'b0, want.done}, {12'b0, got.done});
                end
            end
            if (s_tvalid && s_tready)
                predicted_groups.push_back(next_pixel_group(s_tdata[0]));
            outstanding = predicted_groups.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives restart and advance items into the midpoint ellipse rasterizer over
// many radius and centre settings, with random idling on both streams and a
// long receiver hold-off; the checker predicts and compares every group.
// ----------------------------------------------------------------------------
module tb;
    import mer_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 12;
    localparam int QUIET_LIMIT  = 2000;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;
    logic                      cfg_we    = 1'b0;
    cfg_reg_t                  cfg_addr  = REG_RADIUS_X;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    int unsigned outstanding;
    int unsigned mismatches;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned items_sent  = 0;
    int unsigned hold_cnt    = 0;
    logic        hold_req    = 1'b0;
    logic        hold_seen   = 1'b0;
    int unsigned cur_rx      = 0;
    int unsigned cur_ry      = 0;

    always #10 aclk = ~aclk;

    midpoint_ellipse_rasterizer DUT (.*);

    ellipse_point_checker checker_i (.*);

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt  <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles with no transfer on either stream
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic restart);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_BITS-1){1'b0}}, restart};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // stop offering and wait until every group has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_ellipse(input logic [CFG_DATA_BITS-1:0] rx,
                               input logic [CFG_DATA_BITS-1:0] ry,
                               input logic [CFG_DATA_BITS-1:0] cx,
                               input logic [CFG_DATA_BITS-1:0] cy);
        drain();
        write_reg(REG_RADIUS_X, rx);
        write_reg(REG_RADIUS_Y, ry);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
    endtask

    function automatic logic [COORD_BITS-1:0] pick_center();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return COORD_BITS'($urandom_range((1 << COORD_BITS) - 1));
        endcase
    endfunction

    // one walk: mostly small radii run to the end, large ones cut short
    task automatic random_walk(input bit hold_first);
        int unsigned kind, n_adv;
        if (hold_first || $urandom_range(9) < 7) begin
            kind = $urandom_range(99);
            if (kind < 80) begin
                cur_rx = ($urandom_range(9) == 0) ? 0 : $urandom_range(24, 1);
                cur_ry = ($urandom_range(9) == 0) ? 0 : $urandom_range(24, 1);
            end else if (kind < 86) begin
                cur_rx = $urandom_range(1023, 512);
                cur_ry = $urandom_range(24);
            end else if (kind < 92) begin
                cur_rx = $urandom_range(24);
                cur_ry = $urandom_range(1023, 512);
            end else begin
                cur_rx = $urandom_range(1023);
                cur_ry = $urandom_range(1023);
            end
            set_ellipse(CFG_DATA_BITS'(cur_rx), CFG_DATA_BITS'(cur_ry),
                        pick_center(), pick_center());
        end
        if (hold_first) begin
            @(negedge aclk);
            hold_req <= ~hold_req;
        end
        if (cur_rx + cur_ry > 48)
            n_adv = $urandom_range(30, 3);
        else if ($urandom_range(9) == 0)
            n_adv = $urandom_range(cur_rx + cur_ry);
        else
            n_adv = cur_rx + cur_ry + $urandom_range(2);
        // stray advances ahead of the restart
        if ($urandom_range(19) == 0)
            repeat ($urandom_range(3, 1)) send_item(1'b0);
        send_item(1'b1);
        repeat (n_adv) send_item(1'b0);
    endtask

    initial begin
        int unsigned base;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // advance on the reset walk, then restart with both radii zero
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        // one radius zero
        set_ellipse(0, 5, 100, 200);
        send_item(1'b1);
        send_item(1'b0);
        set_ellipse(7, 0, 2047, 0);
        send_item(1'b1);
        // tiny ellipse at the origin, coordinates go negative
        set_ellipse(1, 1, 0, 0);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        // largest radii at both centre extremes
        set_ellipse(1023, 1023, 2047, 2047);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        set_ellipse(1023, 1023, 0, 0);
        send_item(1'b1);
        send_item(1'b0);
        // tall ellipse enters region two on the second advance
        set_ellipse(2, 1023, 1024, 1024);
        send_item(1'b1);
        repeat (2) send_item(1'b0);
        // full walk through both regions, last point and past the end
        set_ellipse(5, 3, 1024, 1024);
        send_item(1'b1);
        repeat (9) send_item(1'b0);

        // random walks under three idling patterns
        base = items_sent;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 26;
                    rx_idle_pct <= 67;
                end
                1: begin
                    tx_idle_pct = 67;
                    rx_idle_pct <= 26;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            random_walk(ph != 1);
            while (items_sent < base + (ph + 1) * RANDOM_ITEMS / 3)
                random_walk(1'b0);
        end

        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mer_pkg.sv
hw/rtl/mer_cfg.sv
hw/rtl/mer_datapath.sv
hw/rtl/mer_ctrl.sv
hw/rtl/midpoint_ellipse_rasterizer.sv
test/ellipse_point_checker.sv
test/tb.sv
